[src/hthp_pkg.sv]
package hthp_pkg;

  localparam int IMAGE_BYTES  = 512;
  localparam int PATCH_OFFSET = 68;
  localparam int PATCH_LEN    = 12;

  localparam logic [15:0] LINE_MAX = 16'd65534;
  localparam logic [7:0]  CHAR_NL  = 8'h0A;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_ERROR   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_LOAD_SIZE = 1'b0,
    CFG_TEXT_BASE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [8:0]  byte_index;
    logic [15:0] line_number;
    logic [9:0]  byte_total;
    logic        overflow;
    logic        last;
  } out_item_t;

  // All results one character causes, queued for the output stage.
  typedef struct packed {
    logic [2:0]       n_data;
    logic             err;
    logic             summ;
    logic [3:0][7:0]  bytes;
    logic [9:0]       base;
    logic [15:0]      line_a;
    logic [15:0]      line_b;
    logic [9:0]       total_b;
    logic             drop_a;
    logic             drop_b;
  } batch_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= "0" && c <= "9") begin
      v = c - 8'h30;
      return {1'b1, v[3:0]};
    end
    if (c >= "a" && c <= "f") begin
      v = c - 8'h57;
      return {1'b1, v[3:0]};
    end
    if (c >= "A" && c <= "F") begin
      v = c - 8'h37;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [7:0] patch_byte(input logic [9:0] pos, input logic [7:0] b,
                                            input logic [31:0] load_size,
                                            input logic [31:0] text_base);
    logic [9:0]  rel;
    logic [31:0] word;
    rel  = pos - 10'(PATCH_OFFSET);
    word = (rel < 10'd4) ? load_size : text_base;
    if (pos >= 10'(PATCH_OFFSET) && rel < 10'(PATCH_LEN)) begin
      return word[{rel[1:0], 3'b000} +: 8];
    end
    return b;
  endfunction

endpackage

[src/hex_text_header_parser.sv]
// Hex text header parser.
// Input channel (in_valid/in_ready/in_data) takes one text character per
// transaction. Hex digits build a token; the first other character ends it
// and the rest of the line is skipped. Tokens of 2, 4 or 8 digits yield 1, 2
// or 4 image bytes, low byte first; other lengths yield a line error. A
// character flagged end_of_text is followed by an end summary.
// Output channel (out_valid/out_ready/out_data) gives one result per
// transaction; last marks the final result of a character.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready
// and writes load_size or text_base; write only while idle.
// A character's results are queued in the batch register when it is
// accepted; the single output register then drains them one per cycle
// while the receiver is ready. A new character is accepted once the last
// queued result moves to the output register, or at once if none.
// A stalled receiver holds the output register; one character's results
// stay queued behind it and further characters wait.
// Reset clears parser state, counters and both config registers.
module hex_text_header_parser
  import hthp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_reg_t    cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] load_size;
  logic [31:0] text_base;

  logic [31:0] token_value, token_value_next;
  logic [3:0]  digit_count, digit_count_next;
  logic        skipping_line, skipping_line_next;
  logic [15:0] line_count, line_count_next;
  logic [9:0]  bytes_done, bytes_done_next;
  logic        dropped_flag, dropped_flag_next;

  logic        accept;
  logic [4:0]  hex;
  logic        ended;
  logic        good_len;
  logic [2:0]  nbytes;
  logic [9:0]  room;
  logic        drop_now;
  logic        is_nl;
  logic [15:0] line_nl;
  batch_t      batch;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_comb begin
    hex      = hex_decode(in_data.text_char);
    ended    = !skipping_line && !hex[4];
    good_len = (digit_count == 4'd2) || (digit_count == 4'd4) || (digit_count == 4'd8);
    nbytes   = (ended && good_len) ? digit_count[3:1] : 3'd0;
    room     = 10'(IMAGE_BYTES) - bytes_done;
    drop_now = {7'd0, nbytes} > room;
    is_nl    = (in_data.text_char == CHAR_NL);
    line_nl  = (is_nl && line_count < LINE_MAX) ? line_count + 16'd1 : line_count;

    batch.n_data = drop_now ? room[2:0] : nbytes;
    batch.err    = ended && !good_len && digit_count != 4'd0;
    batch.summ   = in_data.end_of_text;
    for (int i = 0; i < 4; i++) begin
      batch.bytes[i] = patch_byte(bytes_done + 10'(i), token_value[8*i +: 8],
                                  load_size, text_base);
    end
    batch.base    = bytes_done;
    batch.line_a  = line_count + 16'd1;
    batch.line_b  = line_nl + 16'd1;
    batch.total_b = bytes_done + {7'd0, batch.n_data};
    batch.drop_a  = dropped_flag;
    batch.drop_b  = dropped_flag || drop_now;
  end

  always_comb begin
    token_value_next   = token_value;
    digit_count_next   = digit_count;
    skipping_line_next = skipping_line;
    line_count_next    = line_nl;
    bytes_done_next    = batch.total_b;
    dropped_flag_next  = batch.drop_b;
    if (!skipping_line && hex[4]) begin
      token_value_next = {token_value[27:0], hex[3:0]};
      if (digit_count != 4'd15) begin
        digit_count_next = digit_count + 4'd1;
      end
    end else if (ended) begin
      token_value_next   = token_value >> {nbytes, 3'b000};
      digit_count_next   = 4'd0;
      skipping_line_next = 1'b1;
    end
    if (is_nl) begin
      skipping_line_next = 1'b0;
      token_value_next   = 32'd0;
    end
    if (in_data.end_of_text) begin
      token_value_next   = 32'd0;
      digit_count_next   = 4'd0;
      skipping_line_next = 1'b0;
      line_count_next    = 16'd0;
      bytes_done_next    = 10'd0;
      dropped_flag_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_value   <= 32'd0;
      digit_count   <= 4'd0;
      skipping_line <= 1'b0;
      line_count    <= 16'd0;
      bytes_done    <= 10'd0;
      dropped_flag  <= 1'b0;
    end else if (accept) begin
      token_value   <= token_value_next;
      digit_count   <= digit_count_next;
      skipping_line <= skipping_line_next;
      line_count    <= line_count_next;
      bytes_done    <= bytes_done_next;
      dropped_flag  <= dropped_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_size <= 32'd0;
      text_base <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOAD_SIZE: load_size <= cfg_data;
        CFG_TEXT_BASE: text_base <= cfg_data;
        default: ;
      endcase
    end
  end

  hthp_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .batch_in  (batch),
    .free      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[src/hthp_emit.sv]
module hthp_emit
  import hthp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  batch_t    batch_in,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  batch_t    batch;
  logic [2:0] len;
  logic [2:0] ptr;
  logic       has;
  logic       out_move;
  logic       pop;
  logic [9:0] pos;
  out_item_t  res;

  assign has      = (ptr != len);
  assign out_move = !out_valid || out_ready;
  assign pop      = has && out_move;
  assign free     = !has || (pop && (ptr + 3'd1 == len));
  assign pos      = batch.base + 10'(ptr);

  always_comb begin
    res             = '0;
    res.line_number = batch.line_a;
    res.overflow    = batch.drop_a;
    res.last        = (ptr + 3'd1 == len);
    if (ptr < batch.n_data) begin
      res.kind       = KIND_DATA;
      res.out_byte   = batch.bytes[ptr[1:0]];
      res.byte_index = pos[8:0];
      res.byte_total = pos + 10'd1;
    end else if (batch.err && ptr == batch.n_data) begin
      res.kind       = KIND_ERROR;
      res.byte_total = batch.base;
    end else begin
      res.kind        = KIND_SUMMARY;
      res.line_number = batch.line_b;
      res.byte_total  = batch.total_b;
      res.overflow    = batch.drop_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= 3'd0;
      len <= 3'd0;
    end else if (load) begin
      ptr <= 3'd0;
      len <= batch_in.n_data + 3'(batch_in.err) + 3'(batch_in.summ);
    end else if (pop) begin
      ptr <= ptr + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      batch <= batch_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= res;
    end
  end

endmodule

[src/hthp_checker.sv]
module hthp_checker
  import hthp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input in_item_t    in_data,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data
);

  // a waiting character holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // data byte count runs one past its index
  a_data_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_DATA |->
      out_data.byte_total == {1'b0, out_data.byte_index} + 10'd1)
    else $error("byte_total does not follow byte_index");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_SUMMARY |-> out_data.last)
    else $error("summary not last");

  // results of one character go out without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("gap inside a character's results");

endmodule

bind hex_text_header_parser hthp_checker u_checker (.*);
